### sv/pcm_volume_scaler_macros.svh
// Assertion macros shared by the front end, queue and back end RTL files.
// Standalone header; no dependencies.
`ifndef PCM_VOLUME_SCALER_MACROS_SVH
`define PCM_VOLUME_SCALER_MACROS_SVH

`define PVS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvs: same-cycle check failed");

`define PVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvs: next-cycle check failed");

`endif

### sv/pvs_pkg.sv
// Shared constants and types for the PCM volume scaler.
// No dependencies; imported by every module of the block.
`default_nettype none

package pvs_pkg;

    localparam int unsigned GainDiv    = 1000;
    localparam int unsigned RecipShift = 26;
    localparam int unsigned Recip      = (1 << RecipShift) / GainDiv;
    localparam int unsigned XW         = RecipShift;
    localparam int unsigned ProdW      = XW + 17;
    localparam int unsigned DigitW     = 16;
    localparam int unsigned Digits     = 3;
    localparam int unsigned MagW       = DigitW * Digits;
    localparam int unsigned RemW       = 10;
    localparam int unsigned Stages     = 2 * Digits;
    localparam int unsigned FifoDepth  = 4;
    localparam int unsigned FifoPtrW   = 2;

    localparam logic [MagW-1:0] SatPos16 = MagW'(64'd32767);
    localparam logic [MagW-1:0] SatNeg16 = MagW'(64'd32768);
    localparam logic [MagW-1:0] SatPos32 = MagW'(64'd2147483647);
    localparam logic [MagW-1:0] SatNeg32 = MagW'(64'd2147483648);

    localparam logic [1:0] FMT_16 = 2'd0;
    localparam logic [1:0] FMT_24 = 2'd1;
    localparam logic [1:0] FMT_32 = 2'd2;

    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_FORMAT = 2'd1;
    localparam logic [1:0] REG_MONO   = 2'd2;

    localparam logic [15:0] GAIN_RESET = 16'd50;

    typedef struct packed {
        logic [31:0] sample;
        logic        is16;
        logic        mono;
    } t_entry;

    typedef struct packed {
        logic            neg;
        logic            is16;
        logic            mono;
        logic [MagW-1:0] num;
        logic [MagW-1:0] quo;
        logic [RemW-1:0] rem;
        logic [XW-1:0]   x;
        logic [ProdW-1:0] prod;
    } t_work;

endpackage

`default_nettype wire

### sv/pvs_front.sv
// Front end: configuration registers, byte gathering and sample assembly.
// Depends on pvs_pkg; feeds completed samples to pvs_fifo.
`default_nettype none

`include "pcm_volume_scaler_macros.svh"

module pvs_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [3:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_fifo_full,
    output logic                 o_push,
    output pvs_pkg::t_entry      o_entry,
    output logic      [15:0]     o_gain
);
    import pvs_pkg::*;

    logic [15:0] r_gain;
    logic [1:0]  r_format;
    logic        r_mono;
    logic [23:0] r_gather;
    logic [1:0]  r_pos;
    logic [23:0] n_gather;
    logic [1:0]  n_pos;
    logic        cfg_wr;
    logic        accept;
    logic        done;
    logic [2:0]  need;
    logic [31:0] sample;

    assign cfg_wr     = psel & penable & pwrite;
    assign o_in_ready = !i_fifo_full;
    assign accept     = i_in_valid & o_in_ready;
    assign o_gain     = r_gain;

    always_comb begin
        unique case (r_format)
            FMT_24:  need = 3'd3;
            FMT_32:  need = 3'd4;
            default: need = 3'd2;
        endcase
    end

    assign done = (3'({1'b0, r_pos}) + 3'd1) >= need;

    always_comb begin
        unique case (r_format)
            FMT_24:  sample = {i_data_byte, r_gather[15:0], 8'h00};
            FMT_32:  sample = {i_data_byte, r_gather[23:0]};
            default: sample = {{16{i_data_byte[7]}}, i_data_byte, r_gather[7:0]};
        endcase
    end

    assign o_push        = accept & done;
    assign o_entry.sample = sample;
    assign o_entry.is16  = (r_format != FMT_24) && (r_format != FMT_32);
    assign o_entry.mono  = r_mono;

    always_comb begin
        unique case (paddr[3:2])
            REG_GAIN:   prdata = {16'h0000, r_gain};
            REG_FORMAT: prdata = {30'h0, r_format};
            REG_MONO:   prdata = {31'h0, r_mono};
            default:    prdata = 32'h0;
        endcase
    end

    always_comb begin
        n_gather = r_gather;
        n_pos    = r_pos;
        priority if (cfg_wr && (paddr[3:2] == REG_FORMAT)) begin
            n_gather = '0;
            n_pos    = '0;
        end else if (accept && done) begin
            n_gather = '0;
            n_pos    = '0;
        end else if (accept) begin
            n_gather[{r_pos, 3'b000} +: 8] = i_data_byte;
            n_pos    = r_pos + 2'd1;
        end else begin
            n_gather = r_gather;
            n_pos    = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_format <= FMT_16;
            r_mono   <= 1'b0;
            r_gather <= '0;
            r_pos    <= '0;
        end else begin
            r_gather <= n_gather;
            r_pos    <= n_pos;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_GAIN:   r_gain   <= pwdata[15:0];
                    REG_FORMAT: r_format <= pwdata[1:0];
                    REG_MONO:   r_mono   <= pwdata[0];
                    default:    ;
                endcase
            end
        end
    end

    `PVS_ASSERT_IMPL(a_pos_bound, i_clk, i_rst_n, 1'b1, (3'(r_pos) < need))

endmodule

`default_nettype wire

### sv/pvs_fifo.sv
// Short sample queue between the front end and the scaling pipeline.
// Depends on pvs_pkg for the entry type and depth.
`default_nettype none

`include "pcm_volume_scaler_macros.svh"

module pvs_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire pvs_pkg::t_entry  i_entry,
    input  wire logic             i_pop,
    output pvs_pkg::t_entry       o_entry,
    output logic                  o_full,
    output logic                  o_empty
);
    import pvs_pkg::*;

    t_entry              r_mem [FifoDepth];
    logic [FifoPtrW-1:0] r_wr_ptr;
    logic [FifoPtrW-1:0] r_rd_ptr;
    logic [FifoPtrW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_count == (FifoPtrW+1)'(FifoDepth);
    assign o_empty = r_count == '0;
    assign do_push = i_push & !o_full;
    assign do_pop  = i_pop & !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `PVS_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `PVS_ASSERT_IMPL(a_empty_ptrs, i_clk, i_rst_n, o_empty, (r_wr_ptr == r_rd_ptr))

endmodule

`default_nettype wire

### sv/pvs_back.sv
// Back end: gain multiply, digit-serial divide by 1000, saturation, output.
// Depends on pvs_pkg; pulls samples from pvs_fifo.
`default_nettype none

`include "pcm_volume_scaler_macros.svh"

module pvs_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pvs_pkg::t_entry  i_entry,
    input  wire logic             i_fifo_empty,
    output logic                  o_pop,
    input  wire logic [15:0]      i_gain,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic signed [31:0]    o_scaled_sample,
    output logic                  o_clipped,
    output logic                  o_run_last
);
    import pvs_pkg::*;

    t_work            r_st [Stages+1];
    t_work            n_st [Stages+1];
    logic [Stages:0]  r_v;
    logic             adv;
    logic             in_neg;
    logic [31:0]      in_mag;
    logic [16:0]      qe;
    logic [XW-1:0]    r_full;
    logic             ge;
    logic [16:0]      q;
    logic [XW-1:0]    r_fix;
    t_work            last;
    logic             sat;
    logic [31:0]      word;
    logic             r_out_v;
    logic [31:0]      r_word;
    logic             r_clip;
    logic             r_mono;
    logic             r_second;

    assign o_run_last = !r_mono || r_second;
    assign adv        = !r_out_v || (i_out_ready && o_run_last);
    assign o_pop      = adv && !i_fifo_empty;

    assign in_neg = i_entry.sample[31];
    assign in_mag = in_neg ? (~i_entry.sample + 32'd1) : i_entry.sample;

    always_comb begin
        n_st[0].neg  = in_neg;
        n_st[0].is16 = i_entry.is16;
        n_st[0].mono = i_entry.mono;
        n_st[0].num  = MagW'(in_mag) * MagW'(i_gain);
        n_st[0].quo  = '0;
        n_st[0].rem  = '0;
        n_st[0].x    = '0;
        n_st[0].prod = '0;
        qe     = '0;
        r_full = '0;
        ge     = 1'b0;
        q      = '0;
        r_fix  = '0;
        for (int i = 1; i <= Stages; i++) begin
            n_st[i] = r_st[i-1];
            if (i[0]) begin
                n_st[i].x    = {r_st[i-1].rem, r_st[i-1].num[MagW-1 -: DigitW]};
                n_st[i].prod = ProdW'(n_st[i].x) * ProdW'(Recip);
            end else begin
                qe     = r_st[i-1].prod[ProdW-1 -: 17];
                r_full = r_st[i-1].x - (XW'(qe) * XW'(GainDiv));
                ge     = r_full >= XW'(GainDiv);
                q      = ge ? (qe + 17'd1) : qe;
                r_fix  = ge ? (r_full - XW'(GainDiv)) : r_full;
                n_st[i].quo = {r_st[i-1].quo[MagW-DigitW-1:0], q[DigitW-1:0]};
                n_st[i].rem = r_fix[RemW-1:0];
                n_st[i].num = {r_st[i-1].num[MagW-DigitW-1:0], {DigitW{1'b0}}};
            end
        end
    end

    assign last = r_st[Stages];

    always_comb begin
        if (last.neg) begin
            sat  = last.quo > (last.is16 ? SatNeg16 : SatNeg32);
            word = sat ? (last.is16 ? 32'hFFFF_8000 : 32'h8000_0000)
                       : (~last.quo[31:0] + 32'd1);
        end else begin
            sat  = last.quo > (last.is16 ? SatPos16 : SatPos32);
            word = sat ? (last.is16 ? 32'h0000_7FFF : 32'h7FFF_FFFF) : last.quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i <= Stages; i++) begin
                r_st[i] <= n_st[i];
            end
            r_word <= word;
            r_clip <= sat;
            r_mono <= last.mono;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_out_v  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (adv) begin
                r_v      <= {r_v[Stages-1:0], !i_fifo_empty};
                r_out_v  <= r_v[Stages];
                r_second <= 1'b0;
            end else if (i_out_ready) begin
                r_second <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_scaled_sample = r_word;
    assign o_clipped       = r_clip;

    `PVS_ASSERT_IMPL(a_second_is_mono, i_clk, i_rst_n, (r_out_v && r_second), r_mono)
    `PVS_ASSERT_NEXT(a_mono_pair, i_clk, i_rst_n, (r_out_v && r_mono && !r_second && i_out_ready), (r_out_v && r_second))

endmodule

`default_nettype wire

### sv/pcm_volume_scaler.sv
// Top level of the PCM volume scaler: joins front end, queue and back end.
// Depends on pvs_pkg, pvs_front, pvs_fifo and pvs_back.
//
// Usage: bytes of little-endian PCM enter on i_data_byte with i_in_valid /
// o_in_ready, one per cycle. Every completed sample leaves as one result
// (stereo) or two identical results (mono) on o_out_valid / i_out_ready,
// with o_run_last marking the final result of the byte that finished it.
// Gain, sample format and mono mode are set over the APB port; pready is
// always high and a write lands in the access cycle. Writing the format
// drops any partial sample.
// A sample's result passes through the queue, the multiply stage, three
// two-stage divide-by-1000 digit steps and the output register.
// Throughput: one byte per cycle while o_in_ready is high and one result
// per cycle while i_out_ready is high.
// Reset (synchronous, active low) restores gain 50/1000, 16-bit stereo,
// and empties the queue and pipeline.
// A stalled receiver freezes the pipeline; bytes are still taken until the
// four-entry sample queue fills, then o_in_ready drops.
`default_nettype none

module pcm_volume_scaler (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_data_byte,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic signed [31:0] o_scaled_sample,
    output logic               o_clipped,
    output logic               o_run_last
);
    import pvs_pkg::*;

    t_entry      push_entry;
    t_entry      pop_entry;
    logic        push;
    logic        pop;
    logic        fifo_full;
    logic        fifo_empty;
    logic [15:0] gain;

    assign pready = 1'b1;

    pvs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_entry     (push_entry),
        .o_gain      (gain)
    );

    pvs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    pvs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry         (pop_entry),
        .i_fifo_empty    (fifo_empty),
        .o_pop           (pop),
        .i_gain          (gain),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_scaled_sample (o_scaled_sample),
        .o_clipped       (o_clipped),
        .o_run_last      (o_run_last)
    );

endmodule

`default_nettype wire

### test/tb_pcm_volume_scaler.sv
// Self-checking testbench for pcm_volume_scaler: directed and random byte streams.
// Depends on pvs_pkg and the pcm_volume_scaler RTL; predicts every scaled sample itself.
`timescale 1ns / 1ps

module tb_pcm_volume_scaler;
    import pvs_pkg::*;

    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam logic [1:0] FMT_RESERVED  = 2'd3;
    localparam longint     GAIN_DIVISOR  = 1000;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         RANDOM_PHASES = 12;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               clipped;
        logic               last;
    } t_scaled_out;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [3:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_data_byte = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_scaled_sample;
    logic               o_clipped;
    logic               o_run_last;

    // predictor state
    logic [15:0]  gain_r   = GAIN_RESET;
    logic [1:0]   fmt_r    = FMT_16;
    logic         mono_r   = 1'b0;
    logic [23:0]  gather_r = '0;
    int unsigned  pos_r    = 0;

    t_scaled_out  expected_outputs[$];
    int           error_count    = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    int unsigned  cycle_count    = 0;

    pcm_volume_scaler i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_scaled_sample(o_scaled_sample),
        .o_clipped      (o_clipped),
        .o_run_last     (o_run_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic int unsigned bytes_in_sample();
        if (fmt_r == FMT_24) return 3;
        if (fmt_r == FMT_32) return 4;
        return 2;
    endfunction

    function automatic logic [31:0] register_value(input logic [1:0] idx);
        case (idx)
            REG_GAIN:   return {16'h0, gain_r};
            REG_FORMAT: return {30'h0, fmt_r};
            REG_MONO:   return {31'h0, mono_r};
            default:    return '0;
        endcase
    endfunction

    // Gather one accepted byte and queue the scaled samples it completes.
    task automatic absorb_byte(input logic [7:0] b);
        int unsigned need;
        logic [31:0] word;
        longint      smp, scaled, lo, hi;
        logic        clip;
        int          n;
        need = bytes_in_sample();
        if (pos_r + 1 < need) begin
            gather_r = gather_r | (24'(b) << (8 * pos_r));
            pos_r    = pos_r + 1;
            return;
        end
        lo = longint'(32'sh8000_0000);
        hi = longint'(32'sh7FFF_FFFF);
        case (need)
            2: begin
                word = {16'h0, b, gather_r[7:0]};
                smp  = $signed(word[15:0]);
                lo   = -32768;
                hi   = 32767;
            end
            3: begin
                word = {b, gather_r[15:0], 8'h00};
                smp  = $signed(word);
            end
            default: begin
                word = {b, gather_r};
                smp  = $signed(word);
            end
        endcase
        gather_r = '0;
        pos_r    = 0;
        scaled   = (smp * longint'(gain_r)) / GAIN_DIVISOR;
        clip     = 1'b0;
        if (scaled > hi) begin
            scaled = hi;
            clip   = 1'b1;
        end
        if (scaled < lo) begin
            scaled = lo;
            clip   = 1'b1;
        end
        n = mono_r ? 2 : 1;
        for (int k = 0; k < n; k++) begin
            expected_outputs.push_back('{sample: scaled[31:0], clipped: clip, last: (k == n - 1)});
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_scaled_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outputs.size() == 0) begin
                $display("%0t: unexpected result sample %0d clipped %0b last %0b",
                         $time, o_scaled_sample, o_clipped, o_run_last);
                error_count++;
            end else begin
                want = expected_outputs.pop_front();
                if (o_scaled_sample !== want.sample) begin
                    $display("%0t: sample expected %0d actual %0d",
                             $time, want.sample, o_scaled_sample);
                    error_count++;
                end
                if (o_clipped !== want.clipped) begin
                    $display("%0t: clipped expected %0b actual %0b",
                             $time, want.clipped, o_clipped);
                    error_count++;
                end
                if (o_run_last !== want.last) begin
                    $display("%0t: run_last expected %0b actual %0b",
                             $time, want.last, o_run_last);
                    error_count++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= value;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        absorb_byte(value);
    endtask

    // Drop valid, drain expected results, then hold for the pipeline depth.
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (wr) begin
            case (idx)
                REG_GAIN: gain_r = wdata[15:0];
                REG_FORMAT: begin
                    fmt_r    = wdata[1:0];
                    gather_r = '0;
                    pos_r    = 0;
                end
                REG_MONO: mono_r = wdata[0];
                default: ;
            endcase
        end
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_transfer(1'b1, idx, value, unused);
    endtask

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] got;
        apb_transfer(1'b0, idx, '0, got);
        if (got !== register_value(idx)) begin
            $display("%0t: register %0d expected %0h actual %0h",
                     $time, idx, register_value(idx), got);
            error_count++;
        end
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_reset_values();
        check_reg(REG_GAIN);
        check_reg(REG_FORMAT);
        check_reg(REG_MONO);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        settle_pipeline();
    endtask

    task automatic test_register_masking();
        write_reg(REG_GAIN, 32'hABCD_FFFF);
        write_reg(REG_FORMAT, 32'hFFFF_FFFE);
        write_reg(REG_MONO, 32'h8000_0003);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        check_reg(REG_GAIN);
        check_reg(REG_FORMAT);
        check_reg(REG_MONO);
    endtask

    task automatic test_saturation();
        // full gain on a 32-bit positive peak, then a 16-bit negative peak
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h7F);
        settle_pipeline();
        write_reg(REG_FORMAT, {30'h0, FMT_16});
        write_reg(REG_MONO, 32'h0);
        send_byte(8'h00);
        send_byte(8'h80);
        settle_pipeline();
    endtask

    task automatic test_unity_24bit_mono();
        write_reg(REG_GAIN, 32'd1000);
        write_reg(REG_FORMAT, {30'h0, FMT_24});
        write_reg(REG_MONO, 32'h1);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        settle_pipeline();
    endtask

    task automatic test_format_write_drops_partial();
        write_reg(REG_FORMAT, {30'h0, FMT_16});
        send_byte(8'h55);
        settle_pipeline();
        write_reg(REG_FORMAT, {30'h0, FMT_16});
        send_byte(8'h34);
        send_byte(8'h12);
        settle_pipeline();
    endtask

    task automatic test_reserved_format();
        write_reg(REG_FORMAT, {30'h0, FMT_RESERVED});
        check_reg(REG_FORMAT);
        send_byte(8'hFF);
        send_byte(8'hFF);
        settle_pipeline();
    endtask

    task automatic test_mono_change_keeps_partial();
        write_reg(REG_FORMAT, {30'h0, FMT_24});
        write_reg(REG_MONO, 32'h1);
        send_byte(8'h11);
        settle_pipeline();
        write_reg(REG_MONO, 32'h0);
        send_byte(8'h22);
        send_byte(8'h33);
        settle_pipeline();
    endtask

    task automatic test_random_traffic();
        logic [15:0] gain;
        logic [1:0]  fmt;
        logic [31:0] junk;
        int unsigned target, sent, cnt, need;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_pipeline();
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(63, 0);
                2: set_idling(0, 63);
                default: set_idling(26, 26);
            endcase
            case (phase % 6)
                0: gain = 16'd0;
                1: gain = 16'hFFFF;
                2: gain = 16'd1000;
                3: gain = 16'($urandom_range(1, 2000));
                default: gain = 16'($urandom);
            endcase
            fmt  = 2'((phase + phase / 4) % 4);
            junk = $urandom;
            write_reg(REG_GAIN, {junk[31:16], gain});
            if (phase % 5 != 4) write_reg(REG_FORMAT, {junk[31:2], fmt});
            write_reg(REG_MONO, {junk[31:1], 1'((phase / 2) % 2)});
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
            need   = bytes_in_sample();
            target = 100 + $urandom_range(0, 25);
            sent   = 0;
            while (sent < target) begin
                cnt = need;
                if ($urandom_range(0, 9) == 0) cnt = $urandom_range(1, need - 1);
                for (int k = 0; k < cnt; k++) send_byte(pick_byte());
                sent += cnt;
            end
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** pcm_volume_scaler: FAILED **");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idling(26, 26);
        test_reset_values();
        test_register_masking();
        test_saturation();
        test_unity_24bit_mono();
        test_format_write_drops_partial();
        test_reserved_format();
        test_mono_change_keeps_partial();
        test_random_traffic();
        settle_pipeline();
        if (error_count == 0) begin
            $display("** pcm_volume_scaler: PASSED **");
        end else begin
            $display("** pcm_volume_scaler: FAILED **");
        end
        $finish;
    end

endmodule
